// ===== hdl/tesq_pkg.sv =====
// Shared types and constants of the timed event schedule queue.
package tesq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned RANK_W   = 16;
  localparam int unsigned HNDL_W   = 8;
  localparam int unsigned IN_DW    = 56;
  localparam int unsigned OUT_DW   = 80;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUE     = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_NONEDUE = 3'd4
  } status_e;

  typedef enum logic {
    REQ_ADD  = 1'b0,
    REQ_STEP = 1'b1
  } req_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_e;

  typedef struct packed {
    logic    load;
    logic    insert;
    logic    pop;
    logic    emit;
    status_e code;
    logic    last;
  } ctrl_cmd_t;

  typedef struct packed {
    req_e req;
    logic empty;
    logic full;
    logic head_due;
    logic next_due;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/tesq_datapath.sv =====
// Sorted cell row, request register and result register of the queue.
module tesq_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tesq_pkg::ctrl_cmd_t         cmd_i,
  output tesq_pkg::dp_stat_t          stat_o,
  input  logic                        req_type_i,
  input  logic [tesq_pkg::IN_DW-1:0]  req_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  out_status_o,
  output logic                        out_last_o,
  output logic [tesq_pkg::OUT_DW-1:0] out_data_o
);
  import tesq_pkg::*;

  // request register
  req_e              req_q;
  logic [TIME_W-1:0] tv_q;
  logic [RANK_W-1:0] rk_q;
  logic [HNDL_W-1:0] hd_q;

  // cell row
  logic [TIME_W-1:0] time_q [CAPACITY];
  logic [TIME_W-1:0] time_d [CAPACITY];
  logic [RANK_W-1:0] rank_q [CAPACITY];
  logic [RANK_W-1:0] rank_d [CAPACITY];
  logic [HNDL_W-1:0] hndl_q [CAPACITY];
  logic [HNDL_W-1:0] hndl_d [CAPACITY];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CAPACITY-1:0] le;

  // result register
  logic              ovalid_q;
  status_e           ostat_q;
  logic              olast_q;
  logic [HNDL_W-1:0] ohndl_q;
  logic [TIME_W-1:0] otime_q;
  logic              ohas_q;
  logic [TIME_W-1:0] onext_q;
  logic [HNDL_W-1:0] ohndl_d;
  logic [TIME_W-1:0] otime_d;
  logic              ohas_d;
  logic [TIME_W-1:0] onext_d;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      le[i] = (count_q > CNT_W'(i)) && ({time_q[i], rank_q[i]} <= {tv_q, rk_q});
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      time_d[i] = time_q[i];
      rank_d[i] = rank_q[i];
      hndl_d[i] = hndl_q[i];
      if (cmd_i.insert) begin
        if (!le[i]) begin
          if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
            time_d[i] = tv_q;
            rank_d[i] = rk_q;
            hndl_d[i] = hd_q;
          end else begin
            time_d[i] = time_q[(i == 0) ? 0 : i - 1];
            rank_d[i] = rank_q[(i == 0) ? 0 : i - 1];
            hndl_d[i] = hndl_q[(i == 0) ? 0 : i - 1];
          end
        end
      end else if (cmd_i.pop && i < CAPACITY - 1) begin
        time_d[i] = time_q[(i < CAPACITY - 1) ? i + 1 : i];
        rank_d[i] = rank_q[(i < CAPACITY - 1) ? i + 1 : i];
        hndl_d[i] = hndl_q[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_e'(req_type_i);
      tv_q  <= req_data_i[TIME_W-1:0];
      rk_q  <= req_data_i[TIME_W +: RANK_W];
      hd_q  <= req_data_i[TIME_W+RANK_W +: HNDL_W];
    end
    for (int i = 0; i < CAPACITY; i++) begin
      time_q[i] <= time_d[i];
      rank_q[i] <= rank_d[i];
      hndl_q[i] <= hndl_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // result fields
  always_comb begin
    ohndl_d = '0;
    otime_d = '0;
    ohas_d  = 1'b1;
    onext_d = time_q[0];
    case (cmd_i.code)
      ST_ADDED: begin
        if (!le[0]) begin
          onext_d = tv_q;
        end
      end
      ST_DUE: begin
        ohndl_d = hndl_q[0];
        otime_d = time_q[0];
        ohas_d  = count_q > CNT_W'(1);
        onext_d = ohas_d ? time_q[1] : '0;
      end
      ST_EMPTY: begin
        ohas_d  = 1'b0;
        onext_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      ostat_q <= cmd_i.code;
      olast_q <= cmd_i.last;
      ohndl_q <= ohndl_d;
      otime_q <= otime_d;
      ohas_q  <= ohas_d;
      onext_q <= onext_d;
    end
  end

  assign stat_o.req      = req_q;
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.full     = (count_q >= CNT_W'(CAPACITY));
  assign stat_o.head_due = (count_q > CNT_W'(0)) && (time_q[0] <= tv_q);
  assign stat_o.next_due = (count_q > CNT_W'(1)) && (time_q[1] <= tv_q);
  assign stat_o.out_free = !ovalid_q || out_ready_i;

  assign out_valid_o  = ovalid_q;
  assign out_status_o = ostat_q;
  assign out_last_o   = olast_q;
  assign out_data_o   = {7'd0, onext_q, ohas_q, otime_q, ohndl_q};

endmodule

// ===== hdl/tesq_ctrl.sv =====
// Controller state machine that sequences adds and releases of the queue.
module tesq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tesq_pkg::dp_stat_t  stat_i,
  output tesq_pkg::ctrl_cmd_t cmd_o
);
  import tesq_pkg::*;

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_valid_i) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (stat_i.out_free) begin
          if (stat_i.req == REQ_ADD || stat_i.empty || !stat_i.head_due ||
              !stat_i.next_due) begin
            state_d = FSM_IDLE;
          end
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.code  = ST_ADDED;
    case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      FSM_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          if (stat_i.req == REQ_ADD) begin
            if (stat_i.full) begin
              cmd_o.code = ST_FULL;
            end else begin
              cmd_o.code   = ST_ADDED;
              cmd_o.insert = 1'b1;
            end
          end else if (stat_i.empty) begin
            cmd_o.code = ST_EMPTY;
          end else if (!stat_i.head_due) begin
            cmd_o.code = ST_NONEDUE;
          end else begin
            cmd_o.code = ST_DUE;
            cmd_o.pop  = 1'b1;
            cmd_o.last = !stat_i.next_due;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/timed_event_schedule_queue.sv =====
// Top level of the timed event schedule queue: stream ports, controller and datapath.
//
// Holds up to CAPACITY (16) entries sorted by due time, then by rank, equal keys in
// the order they were added, in a row of shifting cells. Each input transaction is
// an add (tuser 0) or a step to a current time (tuser 1). An add first takes the
// transaction into the request register; then every cell compares its key with the
// new one in parallel and the row shifts to open the slot. A step first captures
// the request, then releases entries one by one: the head cell is compared with the
// current time and popped, the row shifting up by one per released entry, until the
// next entry is not due; a step that only reports an empty store or nothing due
// releases nothing. Results pass through one output register; the next request is
// taken while the last result still waits on the master side, and a stall there
// holds the release sequence. Add to a full store drops the entry and reports
// status 1. The last result caused by a request carries tlast. No clearing pass is
// needed after reset: the fill count alone marks the cells that hold entries.
module timed_event_schedule_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [31:0] time_value, [47:32] order_rank, [55:48] entry_handle
  input  logic [tesq_pkg::IN_DW-1:0]  s_axis_tdata_i,
  // [0] req_type
  input  logic                        s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [7:0] out_handle, [39:8] out_time, [40] has_next, [72:41] next_time, [79:73] zero
  output logic [tesq_pkg::OUT_DW-1:0] m_axis_tdata_o,
  // [2:0] status
  output logic [2:0]                  m_axis_tuser_o,
  // last_flag
  output logic                        m_axis_tlast_o
);
  import tesq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequence each request: capture, then insert or release head by head
  tesq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // cell row, request register and output register
  tesq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_type_i   (s_axis_tuser_i),
    .req_data_i   (s_axis_tdata_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o),
    .out_data_o   (m_axis_tdata_o)
  );

endmodule
